// ----- src/sisp_pkg.sv -----
package sisp_pkg;

	localparam logic [31:0] SPV_MAGIC      = 32'h0723_0203;
	localparam logic [15:0] OP_VECTOR      = 16'd23;
	localparam logic [15:0] OP_POINTER     = 16'd32;
	localparam logic [15:0] OP_VARIABLE    = 16'd59;
	localparam logic [15:0] OP_DECORATE    = 16'd71;
	localparam logic [15:0] OP_MEMBER_DEC  = 16'd72;
	localparam logic [31:0] DEC_LOCATION   = 32'd30;
	localparam logic [2:0]  HDR_WORDS      = 3'd5;

	// Word classes handed from the framing front to the decode back.
	typedef enum logic [1:0] {
		TOK_MAGIC,
		TOK_HDR,
		TOK_OPWORD,
		TOK_OPERAND
	} tok_tag_t;

	typedef enum logic [2:0] {
		KIND_HEADER,
		KIND_BAD_MAGIC,
		KIND_VECTOR,
		KIND_POINTER,
		KIND_VARIABLE,
		KIND_DECORATE,
		KIND_MEMBER_DEC,
		KIND_SHORT
	} rec_kind_t;

	typedef struct packed {
		tok_tag_t    tag;
		logic [1:0]  idx;    // header field index
		logic [31:0] word;
	} token_t;

	typedef struct packed {
		rec_kind_t   kind;
		logic [31:0] field_a;
		logic [31:0] field_b;
		logic [31:0] field_c;
		logic [31:0] field_d;
		logic        has_fourth;
	} record_t;

	// Word count with zero taken as one.
	function automatic logic [15:0] word_count(input logic [31:0] w);
		logic [15:0] n;
		n = w[31:16];
		return (n == 16'd0) ? 16'd1 : n;
	endfunction

	// Minimum word count of a decoded opcode, zero when not decoded.
	function automatic logic [2:0] min_length(input logic [15:0] op);
		logic [2:0] m;
		m = 3'd0;
		if (op == OP_VECTOR || op == OP_POINTER || op == OP_VARIABLE ||
		    op == OP_MEMBER_DEC)
			m = 3'd4;
		else if (op == OP_DECORATE)
			m = 3'd3;
		return m;
	endfunction

	// Operands used, given how many are captured and the decoration word.
	function automatic logic [2:0] operands_needed(input logic [15:0] op,
	                                               input logic [15:0] len,
	                                               input logic [2:0]  opos,
	                                               input logic [31:0] cap1);
		logic [2:0] n;
		n = 3'd3;
		if (op == OP_VARIABLE)
			n = (len > 16'd4) ? 3'd4 : 3'd3;
		else if (op == OP_DECORATE)
			n = (opos >= 3'd2 && cap1 == DEC_LOCATION && len > 16'd3) ? 3'd3 : 3'd2;
		return n;
	endfunction

endpackage

// ----- src/sisp_fifo.sv -----
module sisp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- src/sisp_front.sv -----
module sisp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,      // word accepted this cycle
	input  logic [31:0]     word,
	output logic            tok_push,
	output sisp_pkg::token_t tok
);

	logic [2:0]  hdr_pos_q;
	logic        halted_q;
	logic [15:0] remaining_q;

	always_comb begin
		tok.word = word;
		tok.idx  = 2'(hdr_pos_q - 3'd1);
		tok_push = take && !halted_q;
		if (hdr_pos_q == 3'd0)
			tok.tag = sisp_pkg::TOK_MAGIC;
		else if (hdr_pos_q < sisp_pkg::HDR_WORDS)
			tok.tag = sisp_pkg::TOK_HDR;
		else if (remaining_q == 16'd0)
			tok.tag = sisp_pkg::TOK_OPWORD;
		else
			tok.tag = sisp_pkg::TOK_OPERAND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q   <= '0;
			halted_q    <= 1'b0;
			remaining_q <= '0;
		end else if (tok_push) begin
			unique case (tok.tag)
				sisp_pkg::TOK_MAGIC: begin
					if (word != sisp_pkg::SPV_MAGIC)
						halted_q <= 1'b1;
					else
						hdr_pos_q <= 3'd1;
				end
				sisp_pkg::TOK_HDR:     hdr_pos_q   <= hdr_pos_q + 3'd1;
				sisp_pkg::TOK_OPWORD:  remaining_q <= sisp_pkg::word_count(word) - 16'd1;
				sisp_pkg::TOK_OPERAND: remaining_q <= remaining_q - 16'd1;
				default: ;
			endcase
		end
	end

endmodule

// ----- src/sisp_back.sv -----
module sisp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,     // token consumed this cycle
	input  sisp_pkg::token_t  tok,
	output logic              rec_valid,
	output sisp_pkg::record_t rec
);

	logic [15:0] op_q, len_q;
	logic [2:0]  opos_q;
	logic [31:0] cap_q [4];

	logic [31:0] cap_n [4];
	logic [2:0]  opos_n, minlen_tok, minlen_cur, need_cur, need_n;
	logic [15:0] len_tok;
	logic        capture;

	always_comb begin
		for (int i = 0; i < 4; i++)
			cap_n[i] = cap_q[i];
		opos_n     = opos_q;
		capture    = 1'b0;
		rec_valid  = 1'b0;
		rec        = '0;
		len_tok    = sisp_pkg::word_count(tok.word);
		minlen_tok = sisp_pkg::min_length(tok.word[15:0]);
		minlen_cur = sisp_pkg::min_length(op_q);
		need_cur   = sisp_pkg::operands_needed(op_q, len_q, opos_q, cap_q[1]);

		if (minlen_cur != 3'd0 && len_q >= 16'(minlen_cur) && opos_q < need_cur)
			capture = 1'b1;
		if (capture) begin
			cap_n[opos_q[1:0]] = tok.word;
			opos_n = opos_q + 3'd1;
		end
		need_n = sisp_pkg::operands_needed(op_q, len_q, opos_n, cap_n[1]);

		unique case (tok.tag)
			sisp_pkg::TOK_MAGIC: begin
				rec.kind    = sisp_pkg::KIND_BAD_MAGIC;
				rec.field_a = tok.word;
				rec_valid   = (tok.word != sisp_pkg::SPV_MAGIC);
			end
			sisp_pkg::TOK_HDR: begin
				rec.kind       = sisp_pkg::KIND_HEADER;
				rec.field_a    = cap_q[0];
				rec.field_b    = cap_q[1];
				rec.field_c    = cap_q[2];
				rec.field_d    = tok.word;
				rec.has_fourth = 1'b1;
				rec_valid      = (tok.idx == 2'd3);
			end
			sisp_pkg::TOK_OPWORD: begin
				rec.kind    = sisp_pkg::KIND_SHORT;
				rec.field_a = {16'd0, tok.word[15:0]};
				rec.field_b = {16'd0, len_tok};
				rec_valid   = (minlen_tok != 3'd0) && (len_tok < 16'(minlen_tok));
			end
			sisp_pkg::TOK_OPERAND: begin
				rec.field_a = cap_n[0];
				rec.field_b = cap_n[1];
				rec.field_c = cap_n[2];
				rec_valid   = capture && (opos_n == need_n);
				unique case (op_q)
					sisp_pkg::OP_VECTOR:  rec.kind = sisp_pkg::KIND_VECTOR;
					sisp_pkg::OP_POINTER: rec.kind = sisp_pkg::KIND_POINTER;
					sisp_pkg::OP_VARIABLE: begin
						rec.kind = sisp_pkg::KIND_VARIABLE;
						if (opos_n == 3'd4) begin
							rec.field_d    = cap_n[3];
							rec.has_fourth = 1'b1;
						end
					end
					sisp_pkg::OP_DECORATE: begin
						rec.kind    = sisp_pkg::KIND_DECORATE;
						rec.field_c = '0;
						if (opos_n == 3'd3) begin
							rec.field_d    = cap_n[2];
							rec.has_fourth = 1'b1;
						end
					end
					default: rec.kind = sisp_pkg::KIND_MEMBER_DEC;
				endcase
			end
			default: ;
		endcase
	end

	// Operand capture; header fields share the same slots.
	always_ff @(posedge clk) begin
		if (fire) begin
			if (tok.tag == sisp_pkg::TOK_HDR)
				cap_q[tok.idx] <= tok.word;
			else if (tok.tag == sisp_pkg::TOK_OPERAND && capture)
				cap_q[opos_q[1:0]] <= tok.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= '0;
			len_q  <= '0;
			opos_q <= '0;
		end else if (fire) begin
			if (tok.tag == sisp_pkg::TOK_OPWORD) begin
				op_q   <= tok.word[15:0];
				len_q  <= len_tok;
				opos_q <= '0;
			end else if (tok.tag == sisp_pkg::TOK_OPERAND) begin
				opos_q <= opos_n;
			end
		end
	end

endmodule

// ----- src/spirv_instruction_stream_parser.sv -----
// SPIR-V instruction stream parser. Feed the module one 32-bit word per
// request on push/full, in file order, starting with the magic number; pull
// records on empty/pop. The five header words give one header record (or a
// bad-magic record, after which every word is dropped until reset). After
// that each instruction is framed by its opcode word; OpTypeVector,
// OpTypePointer, OpVariable, OpDecorate and OpMemberDecorate each give one
// record on the word that completes their last used operand, a too-short
// one gives a short-instruction record on its opcode word, and everything
// else is skipped. Throughput is one word per cycle while no queue is full:
// the framing front takes a word every cycle into a small token queue, and
// the decode back drains one token per cycle into the result queue. Records
// reach the ports via both registered queues. full rises only when the token
// queue fills, i.e. when records are not popped for a while.
module spirv_instruction_stream_parser #(
	parameter int TOKEN_DEPTH  = 4,   // words in flight between front and back
	parameter int RESULT_DEPTH = 2    // records waiting to be popped
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [31:0] word,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output logic [2:0]  kind,
	output logic [31:0] field_a,
	output logic [31:0] field_b,
	output logic [31:0] field_c,
	output logic [31:0] field_d,
	output logic        has_fourth
);

	localparam int TOK_W = $bits(sisp_pkg::token_t);
	localparam int REC_W = $bits(sisp_pkg::record_t);

	sisp_pkg::token_t  tok_in, tok_out;
	sisp_pkg::record_t rec_in, rec_out;
	logic              take, tok_push, tq_empty, rq_full, rq_empty, fire, rec_valid;
	logic [TOK_W-1:0]  tq_rdata;
	logic [REC_W-1:0]  rq_rdata;

	assign take = push && !full;

	// Front: header tracking and instruction framing.
	sisp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.word     (word),
		.tok_push (tok_push),
		.tok      (tok_in)
	);

	sisp_fifo #(.WIDTH(TOK_W), .DEPTH(TOKEN_DEPTH)) u_tok_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tok_push),
		.wdata  (tok_in),
		.full   (full),
		.pop    (fire),
		.rdata  (tq_rdata),
		.empty  (tq_empty)
	);

	assign tok_out = sisp_pkg::token_t'(tq_rdata);
	// Back advances whenever it has a token and room for a possible record.
	assign fire    = !tq_empty && !rq_full;

	// Back: operand capture and record assembly.
	sisp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.tok       (tok_out),
		.rec_valid (rec_valid),
		.rec       (rec_in)
	);

	sisp_fifo #(.WIDTH(REC_W), .DEPTH(RESULT_DEPTH)) u_rec_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fire && rec_valid),
		.wdata  (rec_in),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_rdata),
		.empty  (rq_empty)
	);

	assign rec_out    = sisp_pkg::record_t'(rq_rdata);
	assign empty      = rq_empty;
	assign kind       = rec_out.kind;
	assign field_a    = rec_out.field_a;
	assign field_b    = rec_out.field_b;
	assign field_c    = rec_out.field_c;
	assign field_d    = rec_out.field_d;
	assign has_fourth = rec_out.has_fourth;

endmodule

// ----- src/sisp_checker.sv -----
module sisp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pop,
	input logic        empty,
	input logic [2:0]  kind,
	input logic [31:0] field_a,
	input logic [31:0] field_b,
	input logic [31:0] field_c,
	input logic [31:0] field_d,
	input logic        has_fourth
);

	// A waiting record holds until popped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(kind) && $stable(field_a) &&
		$stable(field_b) && $stable(field_c) && $stable(field_d) &&
		$stable(has_fourth))
		else $error("record changed while waiting");

	a_header: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind == sisp_pkg::KIND_HEADER |-> has_fourth)
		else $error("header record without fourth field");

	a_bad_magic: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind == sisp_pkg::KIND_BAD_MAGIC |->
		field_b == '0 && field_c == '0 && field_d == '0 && !has_fourth)
		else $error("bad-magic record carries operands");

	a_three_op: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (kind == sisp_pkg::KIND_VECTOR || kind == sisp_pkg::KIND_POINTER ||
		kind == sisp_pkg::KIND_MEMBER_DEC || kind == sisp_pkg::KIND_SHORT) |->
		!has_fourth && field_d == '0)
		else $error("fourth field on a three-operand record");

	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind == sisp_pkg::KIND_SHORT |->
		field_a[31:16] == '0 && field_b[31:16] == '0 && field_b[15:0] != '0 &&
		field_c == '0)
		else $error("malformed short-instruction record");

endmodule

bind spirv_instruction_stream_parser sisp_checker u_sisp_checker (.*);

// ----- sim/tb.sv -----
// Scoreboard for the instruction stream parser. It keeps its own copy of the
// framing state, turns every accepted word into the record it should cause
// (if any) and matches the records popped from the block against them.
class parse_scoreboard;
	sisp_pkg::record_t expected_records[$];
	int          errors;
	int          kind_seen[8];
	int          words_taken;

	// framing state
	bit [2:0]    hdr_pos;
	bit          halted;
	bit [15:0]   op;
	bit [15:0]   len;
	bit [15:0]   remaining;
	bit [2:0]    opos;
	bit [31:0]   cap[4];

	function new();
		errors      = 0;
		words_taken = 0;
		hdr_pos     = '0;
		halted      = 1'b0;
		op          = '0;
		len         = '0;
		remaining   = '0;
		opos        = '0;
		foreach (cap[i]) cap[i] = '0;
		foreach (kind_seen[i]) kind_seen[i] = 0;
	endfunction

	// Shortest legal word count of a decoded opcode; 0 = not decoded.
	static function bit [2:0] min_words(bit [15:0] code);
		if (code == sisp_pkg::OP_VECTOR || code == sisp_pkg::OP_POINTER ||
		    code == sisp_pkg::OP_VARIABLE || code == sisp_pkg::OP_MEMBER_DEC)
			return 3'd4;
		if (code == sisp_pkg::OP_DECORATE)
			return 3'd3;
		return 3'd0;
	endfunction

	// Operands the current instruction uses. OpDecorate takes a third one
	// only when the decoration is Location and the word count leaves room.
	function bit [2:0] used_operands();
		if (op == sisp_pkg::OP_VARIABLE)
			return (len > 16'd4) ? 3'd4 : 3'd3;
		if (op == sisp_pkg::OP_DECORATE)
			return (opos >= 3'd2 && cap[1] == sisp_pkg::DEC_LOCATION && len > 16'd3)
			       ? 3'd3 : 3'd2;
		return 3'd3;
	endfunction

	function sisp_pkg::record_t make_rec(sisp_pkg::rec_kind_t k, bit [31:0] a,
	                                     bit [31:0] b, bit [31:0] c,
	                                     bit [31:0] d, bit h);
		sisp_pkg::record_t r;
		r.kind       = k;
		r.field_a    = a;
		r.field_b    = b;
		r.field_c    = c;
		r.field_d    = d;
		r.has_fourth = h;
		return r;
	endfunction

	function sisp_pkg::record_t operand_record();
		case (op)
			sisp_pkg::OP_VECTOR:
				return make_rec(sisp_pkg::KIND_VECTOR, cap[0], cap[1], cap[2], '0, 1'b0);
			sisp_pkg::OP_POINTER:
				return make_rec(sisp_pkg::KIND_POINTER, cap[0], cap[1], cap[2], '0, 1'b0);
			sisp_pkg::OP_VARIABLE: begin
				if (opos == 3'd4)
					return make_rec(sisp_pkg::KIND_VARIABLE, cap[0], cap[1], cap[2],
					                cap[3], 1'b1);
				return make_rec(sisp_pkg::KIND_VARIABLE, cap[0], cap[1], cap[2], '0, 1'b0);
			end
			sisp_pkg::OP_DECORATE: begin
				if (opos == 3'd3)
					return make_rec(sisp_pkg::KIND_DECORATE, cap[0], cap[1], '0, cap[2], 1'b1);
				return make_rec(sisp_pkg::KIND_DECORATE, cap[0], cap[1], '0, '0, 1'b0);
			end
			default:
				return make_rec(sisp_pkg::KIND_MEMBER_DEC, cap[0], cap[1], cap[2], '0, 1'b0);
		endcase
	endfunction

	// One accepted word: advance the framing state, queue any record it causes.
	function void take_word(bit [31:0] w);
		bit [2:0] floor_len;
		words_taken++;
		if (halted)
			return;
		if (hdr_pos < 3'd5) begin
			if (hdr_pos == 3'd0) begin
				if (w != sisp_pkg::SPV_MAGIC) begin
					halted = 1'b1;
					expected_records.push_back(make_rec(sisp_pkg::KIND_BAD_MAGIC, w, '0, '0,
					                                    '0, 1'b0));
				end else begin
					hdr_pos = 3'd1;
				end
				return;
			end
			cap[2'(hdr_pos - 3'd1)] = w;
			hdr_pos++;
			if (hdr_pos == 3'd5)
				expected_records.push_back(make_rec(sisp_pkg::KIND_HEADER, cap[0], cap[1],
				                                    cap[2], cap[3], 1'b1));
			return;
		end
		if (remaining == 16'd0) begin
			// opcode word; a zero count means the opcode word alone
			op        = w[15:0];
			len       = (w[31:16] == 16'd0) ? 16'd1 : w[31:16];
			remaining = len - 16'd1;
			opos      = '0;
			floor_len = min_words(op);
			if (floor_len != 3'd0 && len < 16'(floor_len))
				expected_records.push_back(make_rec(sisp_pkg::KIND_SHORT, 32'(op), 32'(len),
				                                    '0, '0, 1'b0));
			return;
		end
		remaining--;
		floor_len = min_words(op);
		if (floor_len == 3'd0 || len < 16'(floor_len))
			return;
		if (opos >= used_operands())
			return;	// surplus word
		cap[opos[1:0]] = w;
		opos++;
		if (opos == used_operands())
			expected_records.push_back(operand_record());
	endfunction

	function int pending();
		return expected_records.size();
	endfunction

	task report(string msg);
		errors++;
		if (errors <= 40)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report($sformatf("%s got %h want %h", name, got, want));
	endtask

	task check_record(logic [2:0] k, logic [31:0] a, logic [31:0] b, logic [31:0] c,
	                  logic [31:0] d, logic h);
		sisp_pkg::record_t r;
		if (expected_records.size() == 0) begin
			report($sformatf("record kind %0d with none expected", k));
			return;
		end
		r = expected_records.pop_front();
		kind_seen[r.kind]++;
		compare_field("kind", 32'(k), 32'(r.kind));
		compare_field("field_a", a, r.field_a);
		compare_field("field_b", b, r.field_b);
		compare_field("field_c", c, r.field_c);
		compare_field("field_d", d, r.field_d);
		compare_field("has_fourth", 32'(h), 32'(r.has_fourth));
	endtask
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Longest stretch with no request accepted on either side. Worst case is
	// a receiver stall on top of a sender gap and the tail wait at the end;
	// this leaves a wide margin.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_WORDS   = 1100;
	localparam int TAIL_CYCLES    = 10;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        push   = 1'b0;
	logic [31:0] word   = '0;
	logic        pop    = 1'b0;
	logic        full;
	logic        empty;
	logic [2:0]  kind;
	logic [31:0] field_a;
	logic [31:0] field_b;
	logic [31:0] field_c;
	logic [31:0] field_d;
	logic        has_fourth;

	parse_scoreboard board;

	// sender bookkeeping
	int          burst_left  = 0;
	logic [31:0] operand_q[$];		// operands for the next instruction
	int          idle_cycles = 0;

	spirv_instruction_stream_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.word       (word),
		.full       (full),
		.pop        (pop),
		.empty      (empty),
		.kind       (kind),
		.field_a    (field_a),
		.field_b    (field_b),
		.field_c    (field_c),
		.field_d    (field_d),
		.has_fourth (has_fourth)
	);

	always #1 clk = ~clk;

	// Result side: a record is taken at a rising edge with pop high and
	// empty low; the fields are compared against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			board.check_record(kind, field_a, field_b, field_c, field_d, has_fourth);
	end

	// Watchdog: ends the run when neither side has moved a request for too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request accepted for %0d cycles, %0d records pending",
				         WATCHDOG_LIMIT, board.pending());
				$display("spirv_instruction_stream_parser verification failed");
				$finish;
			end
		end
	end

	// Receiver stall pattern: runs of steady popping, coin-flip popping,
	// mostly-on popping and one long stall followed by steady popping. The
	// long stalls back the token queue up so that full gets exercised.
	initial begin : receiver
		int mode;
		int span;
		int stall;
		forever begin
			mode  = $urandom_range(0, 3);
			span  = $urandom_range(20, 200);
			stall = $urandom_range(8, 40);
			for (int i = 0; i < span; i++) begin
				@(negedge clk);
				case (mode)
					0:       pop <= 1'b1;
					1:       pop <= 1'($urandom_range(0, 1));
					2:       pop <= ($urandom_range(0, 7) != 0);
					default: pop <= (i >= stall);
				endcase
			end
		end
	end

	// Push one word. Words go out in bursts of random length; between bursts
	// the sender idles with junk on the word port.
	task automatic push_word(input logic [31:0] w);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 16);
			gap = $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
				word <= $urandom;
			end
		end
		burst_left--;
		@(negedge clk);
		push <= 1'b1;
		word <= w;
		do @(posedge clk); while (full !== 1'b0);
		board.take_word(w);
	endtask

	// Hold off the sender until every expected record has been popped.
	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// Mostly random operands, with the all-zero and all-one words mixed in.
	function automatic logic [31:0] any_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// One instruction: opcode word {count, opcode}, then count-1 words, or none
	// for a zero count, from operand_q first and random words after that.
	task automatic send_instr(input logic [15:0] code, input logic [15:0] cnt);
		int n;
		n = (cnt == 16'd0) ? 1 : int'(cnt);
		push_word({cnt, code});
		for (int i = 1; i < n; i++)
			push_word(operand_q.size() != 0 ? operand_q.pop_front() : any_word());
		operand_q.delete();
	endtask

	function automatic logic [15:0] decoded_op();
		case ($urandom_range(0, 4))
			0:       return sisp_pkg::OP_VECTOR;
			1:       return sisp_pkg::OP_POINTER;
			2:       return sisp_pkg::OP_VARIABLE;
			3:       return sisp_pkg::OP_DECORATE;
			default: return sisp_pkg::OP_MEMBER_DEC;
		endcase
	endfunction

	// Random instruction mix: mostly well-formed decoded instructions (some
	// with surplus words), then too-short ones, skipped opcodes with small
	// counts, and now and then a longer skipped instruction.
	task automatic random_instr();
		int          pick;
		logic [15:0] code;
		logic [15:0] cnt;
		logic [2:0]  floor_len;
		pick = $urandom_range(0, 99);
		if (pick < 62) begin
			code      = decoded_op();
			floor_len = sisp_pkg::min_length(code);
			cnt       = 16'(floor_len) + 16'((($urandom_range(0, 3) == 0)
			                                  ? $urandom_range(1, 5)
			                                  : $urandom_range(0, 1)));
			if (code == sisp_pkg::OP_DECORATE) begin
				// Location half the time, so the optional third operand shows up
				operand_q.push_back(any_word());
				operand_q.push_back($urandom_range(0, 1) ? sisp_pkg::DEC_LOCATION
				                                         : any_word());
			end
			send_instr(code, cnt);
		end else if (pick < 74) begin
			code      = decoded_op();
			floor_len = sisp_pkg::min_length(code);
			send_instr(code, 16'($urandom_range(0, int'(floor_len) - 1)));
		end else if (pick < 95) begin
			send_instr(16'($urandom), 16'($urandom_range(0, 8)));
		end else begin
			send_instr(16'($urandom), 16'($urandom_range(9, 120)));
		end
	endtask

	initial begin : stimulus
		bit long_done;
		int next_drain;
		board      = new();
		long_done  = 1'b0;
		next_drain = 350;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// --- directed part ---
		// header with extreme field values
		push_word(sisp_pkg::SPV_MAGIC);
		push_word(32'h0001_0600);
		push_word('1);
		push_word('0);
		push_word(32'hA5A5_5A5A);

		// vector with extreme operands
		operand_q = '{32'hFFFF_FFFF, 32'h0, 32'd4};
		send_instr(sisp_pkg::OP_VECTOR, 16'd4);
		operand_q = '{32'd7, 32'd12, 32'hFFFF_FFFF};
		send_instr(sisp_pkg::OP_POINTER, 16'd4);
		// variable with initializer
		operand_q = '{32'd9, 32'd10, 32'd7, 32'd0};
		send_instr(sisp_pkg::OP_VARIABLE, 16'd5);
		// Location decoration with a location operand
		operand_q = '{32'd10, sisp_pkg::DEC_LOCATION, 32'hFFFF_FFFF};
		send_instr(sisp_pkg::OP_DECORATE, 16'd4);
		operand_q = '{32'd20, 32'd0, 32'd11};
		send_instr(sisp_pkg::OP_MEMBER_DEC, 16'd4);
		// zero count on a decoded opcode: one word, and too short
		send_instr(sisp_pkg::OP_DECORATE, 16'd0);
		// zero count on a skipped opcode
		send_instr(16'hFFFF, 16'd0);

		// --- random part ---
		while (board.words_taken < RANDOM_WORDS) begin
			random_instr();
			if (board.words_taken >= next_drain) begin
				wait_drained();
				next_drain += 350;
			end
			// one variable with a long word count: the record comes after
			// four operands and the rest is surplus that must keep framing
			if (!long_done && board.words_taken >= 500) begin
				send_instr(sisp_pkg::OP_VARIABLE, 16'd120);
				long_done = 1'b1;
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d words pushed; records: header %0d vector %0d pointer %0d variable %0d",
		         board.words_taken, board.kind_seen[sisp_pkg::KIND_HEADER],
		         board.kind_seen[sisp_pkg::KIND_VECTOR],
		         board.kind_seen[sisp_pkg::KIND_POINTER],
		         board.kind_seen[sisp_pkg::KIND_VARIABLE]);
		$display("decorate %0d member %0d short %0d; %0d mismatches (bad magic needs a reset)",
		         board.kind_seen[sisp_pkg::KIND_DECORATE],
		         board.kind_seen[sisp_pkg::KIND_MEMBER_DEC],
		         board.kind_seen[sisp_pkg::KIND_SHORT], board.errors);
		if (board.errors == 0)
			$display("spirv_instruction_stream_parser verification clean");
		else
			$display("spirv_instruction_stream_parser verification failed");
		$finish;
	end
endmodule

// ----- filelist.f -----
src/sisp_pkg.sv
src/sisp_fifo.sv
src/sisp_front.sv
src/sisp_back.sv
src/spirv_instruction_stream_parser.sv
src/sisp_checker.sv
sim/tb.sv
